### rtl/four_wheel_drive_mixer_core_macros.svh
`ifndef FOUR_WHEEL_DRIVE_MIXER_CORE_MACROS_SVH
`define FOUR_WHEEL_DRIVE_MIXER_CORE_MACROS_SVH

// same-cycle check, sampled on clk, off during reset
`define FWDM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fwdm check failed");

// next-cycle check, sampled on clk, off during reset
`define FWDM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fwdm check failed");

`endif

### rtl/fwdm_pkg.sv
package fwdm_pkg;

	localparam logic [7:0] SPEED_MAX = 8'd249;
	localparam logic signed [7:0] PERCENT_FULL = 8'sd100;

	// floor(a * 249 / 100) == (a * MAG_RECIP) >> MAG_SHIFT for a in 0..100
	localparam logic [17:0] MAG_RECIP = 18'd163185;
	localparam int MAG_SHIFT = 16;

	// floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2048
	localparam logic [11:0] DIV3_RECIP = 12'd2731;
	localparam int DIV3_SHIFT = 13;

	typedef logic [7:0] spd_t;
	typedef logic [9:0] raw_spd_t;
	typedef logic [10:0] excess_t;

	typedef struct packed {
		logic signed [7:0] lateral_demand;
		logic signed [7:0] forward_demand;
		logic signed [7:0] turn_demand;
	} cmd_t;

	typedef struct packed {
		logic motor_a_dir;
		spd_t motor_a_speed;
		logic motor_b_dir;
		spd_t motor_b_speed;
		logic motor_c_dir;
		spd_t motor_c_speed;
		logic motor_d_dir;
		spd_t motor_d_speed;
	} res_t;

	typedef struct packed {
		logic nz;
		logic neg;
		spd_t mag;
	} term_t;

	typedef struct packed {
		term_t lat;
		term_t fwd;
		term_t turn;
	} terms_t;

	typedef struct packed {
		logic [3:0] dir;
		raw_spd_t [3:0] spd;
	} mix_t;

	typedef struct packed {
		logic [3:0] dir;
		spd_t [3:0] spd;
		excess_t excess;
		logic [2:0] below;
	} clip_t;

	typedef struct packed {
		logic [3:0] dir;
		spd_t [3:0] spd;
		excess_t share;
		logic share_en;
	} share_t;

endpackage

### rtl/fwdm_stream_if.sv
interface fwdm_stream_if #(
	parameter type payload_t = fwdm_pkg::cmd_t
) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/fwdm_scale.sv
module fwdm_scale (
	input fwdm_pkg::cmd_t cmd,
	output fwdm_pkg::terms_t terms
);

	function automatic fwdm_pkg::term_t scale_one(input logic signed [7:0] raw);
		logic signed [7:0] v;
		logic [6:0] a;
		logic [24:0] p;
		fwdm_pkg::term_t t;
		v = raw;
		if (v > fwdm_pkg::PERCENT_FULL) begin
			v = fwdm_pkg::PERCENT_FULL;
		end else if (v < -fwdm_pkg::PERCENT_FULL) begin
			v = -fwdm_pkg::PERCENT_FULL;
		end
		a = v[7] ? 7'(-v) : 7'(v);
		p = 25'(a) * 25'(fwdm_pkg::MAG_RECIP);
		t.nz = (v != 8'sd0);
		t.neg = v[7];
		t.mag = 8'(p >> fwdm_pkg::MAG_SHIFT);
		return t;
	endfunction

	always_comb begin
		terms.lat = scale_one(cmd.lateral_demand);
		terms.fwd = scale_one(cmd.forward_demand);
		terms.turn = scale_one(cmd.turn_demand);
	end

endmodule

### rtl/fwdm_merge.sv
module fwdm_merge (
	input fwdm_pkg::terms_t terms,
	output fwdm_pkg::mix_t mix
);

	typedef struct packed {
		logic dir;
		fwdm_pkg::raw_spd_t spd;
	} motor_t;

	function automatic motor_t merge_term(input motor_t m, input logic nd,
			input fwdm_pkg::spd_t ns);
		motor_t r;
		fwdm_pkg::raw_spd_t n;
		n = 10'(ns);
		r = m;
		if (m.spd == '0) begin
			r.dir = nd;
			r.spd = n;
		end else if (m.dir == nd) begin
			r.spd = m.spd + n;
		end else if (m.spd >= n) begin
			r.spd = m.spd - n;
		end else begin
			r.spd = n - m.spd;
			r.dir = nd;
		end
		return r;
	endfunction

	motor_t m [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (terms.lat.nz) begin
				m[i].dir = (i % 2 == 0) ? !terms.lat.neg : terms.lat.neg;
				m[i].spd = 10'(terms.lat.mag);
			end else begin
				m[i] = '0;
			end
			if (terms.fwd.nz) begin
				m[i] = merge_term(m[i], !terms.fwd.neg, terms.fwd.mag);
			end
			if (terms.turn.nz) begin
				m[i] = merge_term(m[i], (i < 2) ? !terms.turn.neg : terms.turn.neg,
					terms.turn.mag);
			end
			mix.dir[i] = m[i].dir;
			mix.spd[i] = m[i].spd;
		end
	end

endmodule

### rtl/fwdm_excess.sv
module fwdm_excess (
	input fwdm_pkg::mix_t mix,
	output fwdm_pkg::clip_t clip
);

	always_comb begin
		clip.dir = mix.dir;
		clip.excess = '0;
		clip.below = '0;
		for (int i = 0; i < 4; i++) begin
			if (mix.spd[i] > 10'(fwdm_pkg::SPEED_MAX)) begin
				clip.excess = clip.excess + 11'(mix.spd[i] - 10'(fwdm_pkg::SPEED_MAX));
				clip.spd[i] = fwdm_pkg::SPEED_MAX;
			end else begin
				clip.spd[i] = mix.spd[i][7:0];
				if (mix.spd[i] != '0) begin
					clip.below = clip.below + 3'd1;
				end
			end
		end
	end

endmodule

### rtl/fwdm_rebal.sv
module fwdm_rebal (
	input fwdm_pkg::share_t sh,
	output fwdm_pkg::res_t res
);

	fwdm_pkg::spd_t sp [4];
	logic [3:0] dir;
	fwdm_pkg::excess_t diff [4];

	always_comb begin
		dir = sh.dir;
		for (int i = 0; i < 4; i++) begin
			sp[i] = sh.spd[i];
			diff[i] = sh.share - 11'(sh.spd[i]);
			if (sh.share_en && sh.spd[i] != '0 && sh.spd[i] < fwdm_pkg::SPEED_MAX) begin
				if (11'(sh.spd[i]) >= sh.share) begin
					sp[i] = 8'(11'(sh.spd[i]) - sh.share);
				end else begin
					sp[i] = (diff[i] > 11'(fwdm_pkg::SPEED_MAX)) ?
						fwdm_pkg::SPEED_MAX : diff[i][7:0];
					dir[i] = !sh.dir[i];
				end
			end
		end
		res.motor_a_dir = dir[0];
		res.motor_a_speed = sp[0];
		res.motor_b_dir = dir[1];
		res.motor_b_speed = sp[1];
		res.motor_c_dir = dir[2];
		res.motor_c_speed = sp[2];
		res.motor_d_dir = dir[3];
		res.motor_d_speed = sp[3];
	end

endmodule

### rtl/four_wheel_drive_mixer_core.sv
// four-wheel drive mixer: lateral, forward and turn percent demands in,
// four motor direction/speed pairs out
// channels: cmd carries one command per transaction, res one motor set;
// both are valid/ready streams, a transaction completes when both are high
// path: each command is registered in stages s1 to s5 in order; res.valid is
// the valid bit of s5
// throughput: one command per cycle while res.ready is high, set by
// the five-stage pipeline (scale, merge, clip, share, rebalance); every
// stage register holds a valid bit and any stage with a bubble takes new
// data even while later stages are stalled
// reset: arst_n clears all valid bits, the pipeline comes up empty and
// ready; no clearing pass, no internal state carries between commands
// stall: when res.ready is low the output register holds its transaction
// and earlier stages keep filling until full; cmd.ready then drops
`include "four_wheel_drive_mixer_core_macros.svh"

module four_wheel_drive_mixer_core (
	input logic clk,
	input logic arst_n,
	fwdm_stream_if.sink cmd,
	fwdm_stream_if.source res
);

	fwdm_pkg::terms_t terms_c, data_s1;
	fwdm_pkg::mix_t mix_c, data_s2;
	fwdm_pkg::clip_t clip_c, data_s3;
	fwdm_pkg::share_t share_c, data_s4;
	fwdm_pkg::res_t res_c, data_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic [23:0] div3_prod;
	logic spd_in_range;
	logic clip_seen_s3;

	assign adv_s5 = !v_s5 || res.ready;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;

	assign cmd.ready = adv_s1;
	assign res.valid = v_s5;
	assign res.payload = data_s5;

	fwdm_scale u_scale (.cmd(cmd.payload), .terms(terms_c));
	fwdm_merge u_merge (.terms(data_s1), .mix(mix_c));
	fwdm_excess u_excess (.mix(data_s2), .clip(clip_c));
	fwdm_rebal u_rebal (.sh(data_s4), .res(res_c));

	// excess divided by the number of nonzero motors not above the limit
	always_comb begin
		share_c.dir = data_s3.dir;
		share_c.spd = data_s3.spd;
		share_c.share_en = (data_s3.excess != '0) && (data_s3.below != '0);
		div3_prod = 24'(data_s3.excess) * 24'(fwdm_pkg::DIV3_RECIP);
		unique case (data_s3.below)
			3'd1: share_c.share = data_s3.excess;
			3'd2: share_c.share = data_s3.excess >> 1;
			3'd3: share_c.share = 11'(div3_prod >> fwdm_pkg::DIV3_SHIFT);
			3'd4: share_c.share = data_s3.excess >> 2;
			default: share_c.share = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= cmd.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) data_s1 <= terms_c;
		if (adv_s2) data_s2 <= mix_c;
		if (adv_s3) data_s3 <= clip_c;
		if (adv_s4) data_s4 <= share_c;
		if (adv_s5) data_s5 <= res_c;
	end

	assign spd_in_range = (res.payload.motor_a_speed <= fwdm_pkg::SPEED_MAX) &&
		(res.payload.motor_b_speed <= fwdm_pkg::SPEED_MAX) &&
		(res.payload.motor_c_speed <= fwdm_pkg::SPEED_MAX) &&
		(res.payload.motor_d_speed <= fwdm_pkg::SPEED_MAX);
	assign clip_seen_s3 = (data_s3.spd[0] == fwdm_pkg::SPEED_MAX) ||
		(data_s3.spd[1] == fwdm_pkg::SPEED_MAX) ||
		(data_s3.spd[2] == fwdm_pkg::SPEED_MAX) ||
		(data_s3.spd[3] == fwdm_pkg::SPEED_MAX);

	`FWDM_ASSERT_NOW(a_speed_limit, res.valid, spd_in_range)
	`FWDM_ASSERT_NOW(a_excess_clipped, v_s3 && data_s3.excess != '0, clip_seen_s3)
	`FWDM_ASSERT_NEXT(a_s4_hold, v_s4 && !adv_s4, v_s4 && $stable(data_s4))
	`FWDM_ASSERT_NOW(a_ready_flow, res.ready, cmd.ready)

endmodule

### tb/four_wheel_drive_mixer_core_test.sv
module four_wheel_drive_mixer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPEED_TOP = fwdm_pkg::SPEED_MAX;
	localparam int PCT_TOP = fwdm_pkg::PERCENT_FULL;
	localparam fwdm_pkg::spd_t SPD_FULL = fwdm_pkg::SPEED_MAX;
	localparam int ITEMS_PER_PHASE = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int N_DIRECTED = 24;

	typedef int motor_fields_t [8];

	typedef struct {
		fwdm_pkg::cmd_t cmd;
		bit known;
		fwdm_pkg::res_t want;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fwdm_stream_if #(.payload_t(fwdm_pkg::cmd_t)) cmd_if ();
	fwdm_stream_if #(.payload_t(fwdm_pkg::res_t)) res_if ();

	four_wheel_drive_mixer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	always #5ns clk = ~clk;

	fwdm_pkg::res_t motor_sets_due [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	const string field_names [8] = '{"motor_a_dir", "motor_a_speed", "motor_b_dir",
		"motor_b_speed", "motor_c_dir", "motor_c_speed", "motor_d_dir", "motor_d_speed"};

	const cmd_row_t directed_rows [N_DIRECTED] = '{
		'{'{8'sd0, 8'sd0, 8'sd0}, 1'b1,
			'{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
		'{'{8'sd100, 8'sd0, 8'sd0}, 1'b1,
			'{1'b1, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b0, SPD_FULL}},
		'{'{-8'sd100, 8'sd0, 8'sd0}, 1'b1,
			'{1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL}},
		'{'{8'sd0, 8'sd100, 8'sd0}, 1'b1,
			'{1'b1, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL}},
		'{'{8'sd0, -8'sd100, 8'sd0}, 1'b1,
			'{1'b0, SPD_FULL, 1'b0, SPD_FULL, 1'b0, SPD_FULL, 1'b0, SPD_FULL}},
		'{'{8'sd0, 8'sd0, 8'sd100}, 1'b1,
			'{1'b1, SPD_FULL, 1'b1, SPD_FULL, 1'b0, SPD_FULL, 1'b0, SPD_FULL}},
		'{'{8'sd0, 8'sd0, -8'sd100}, 1'b1,
			'{1'b0, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL}},
		// saturation of out-of-range demands, and small demands
		'{'{8'sd127, 8'sd0, 8'sd0}, 1'b1,
			'{1'b1, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b0, SPD_FULL}},
		'{'{-8'sd128, 8'sd0, 8'sd0}, 1'b1,
			'{1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL}},
		'{'{8'sd0, 8'sd101, 8'sd0}, 1'b1,
			'{1'b1, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL}},
		'{'{8'sd0, 8'sd0, -8'sd101}, 1'b1,
			'{1'b0, SPD_FULL, 1'b0, SPD_FULL, 1'b1, SPD_FULL, 1'b1, SPD_FULL}},
		'{'{8'sd1, 8'sd0, 8'sd0}, 1'b1,
			'{1'b1, 8'd2, 1'b0, 8'd2, 1'b1, 8'd2, 1'b0, 8'd2}},
		'{'{-8'sd1, -8'sd1, -8'sd1}, 1'b0, '0},
		// opposing terms: where they are equal a motor cancels to zero and keeps its direction
		'{'{8'sd50, -8'sd50, 8'sd0}, 1'b0, '0},
		'{'{8'sd0, 8'sd37, -8'sd64}, 1'b0, '0},
		// overflow shared among motors below the limit
		'{'{8'sd100, 8'sd1, 8'sd0}, 1'b0, '0},
		// overflow with no motor left to take it
		'{'{8'sd100, 8'sd100, 8'sd0}, 1'b0, '0},
		// share larger than the speed reverses the motor; further mixed and extreme demands follow
		'{'{8'sd100, 8'sd100, 8'sd1}, 1'b0, '0},
		'{'{8'sd60, 8'sd100, 8'sd100}, 1'b0, '0},
		'{'{8'sd100, 8'sd100, 8'sd99}, 1'b0, '0},
		'{'{8'sd127, 8'sd127, 8'sd127}, 1'b0, '0},
		'{'{-8'sd128, -8'sd128, -8'sd128}, 1'b0, '0},
		'{'{8'sh55, -8'sd86, 8'sh55}, 1'b0, '0},
		'{'{-8'sd86, 8'sh55, -8'sd86}, 1'b0, '0}
	};

	function automatic int clip_pct(logic signed [7:0] raw);
		int v;
		v = raw;
		if (v > PCT_TOP)
			v = PCT_TOP;
		if (v < -PCT_TOP)
			v = -PCT_TOP;
		return v;
	endfunction

	function automatic int pct_to_speed(int v);
		return ((v < 0) ? -v : v) * SPEED_TOP / PCT_TOP;
	endfunction

	function automatic void merge_term(inout logic d, inout int s, input logic nd, input int ns);
		if (s == 0) begin
			d = nd;
			s = ns;
		end else if (d == nd) begin
			s += ns;
		end else if (s >= ns) begin
			s -= ns;
		end else begin
			s = ns - s;
			d = nd;
		end
	endfunction

	function automatic fwdm_pkg::res_t mix_demands(fwdm_pkg::cmd_t c);
		int lat;
		int fwd;
		int trn;
		int m;
		int excess;
		int below;
		int share;
		logic dir [4];
		int spd [4];
		logic up;
		fwdm_pkg::res_t r;
		lat = clip_pct(c.lateral_demand);
		fwd = clip_pct(c.forward_demand);
		trn = clip_pct(c.turn_demand);
		for (int i = 0; i < 4; i++) begin
			dir[i] = 1'b0;
			spd[i] = 0;
		end
		if (lat != 0) begin
			m = pct_to_speed(lat);
			up = (lat > 0);
			dir[0] = up;
			dir[2] = up;
			dir[1] = !up;
			dir[3] = !up;
			for (int i = 0; i < 4; i++)
				spd[i] = m;
		end
		if (fwd != 0) begin
			m = pct_to_speed(fwd);
			for (int i = 0; i < 4; i++)
				merge_term(dir[i], spd[i], fwd > 0, m);
		end
		if (trn != 0) begin
			m = pct_to_speed(trn);
			up = (trn > 0);
			merge_term(dir[0], spd[0], up, m);
			merge_term(dir[1], spd[1], up, m);
			merge_term(dir[2], spd[2], !up, m);
			merge_term(dir[3], spd[3], !up, m);
		end
		excess = 0;
		below = 0;
		for (int i = 0; i < 4; i++) begin
			if (spd[i] > SPEED_TOP) begin
				excess += spd[i] - SPEED_TOP;
				spd[i] = SPEED_TOP;
			end else if (spd[i] > 0) begin
				below++;
			end
		end
		if (excess > 0 && below > 0) begin
			share = excess / below;
			for (int i = 0; i < 4; i++) begin
				if (spd[i] > 0 && spd[i] < SPEED_TOP) begin
					if (spd[i] >= share) begin
						spd[i] -= share;
					end else begin
						spd[i] = share - spd[i];
						dir[i] = !dir[i];
					end
				end
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (spd[i] > SPEED_TOP)
				spd[i] = SPEED_TOP;
			if (spd[i] < 0)
				spd[i] = 0;
		end
		r.motor_a_dir = dir[0];
		r.motor_a_speed = fwdm_pkg::spd_t'(spd[0]);
		r.motor_b_dir = dir[1];
		r.motor_b_speed = fwdm_pkg::spd_t'(spd[1]);
		r.motor_c_dir = dir[2];
		r.motor_c_speed = fwdm_pkg::spd_t'(spd[2]);
		r.motor_d_dir = dir[3];
		r.motor_d_speed = fwdm_pkg::spd_t'(spd[3]);
		return r;
	endfunction

	function automatic motor_fields_t fields_of(fwdm_pkg::res_t r);
		motor_fields_t f;
		f = '{r.motor_a_dir, r.motor_a_speed, r.motor_b_dir, r.motor_b_speed,
			r.motor_c_dir, r.motor_c_speed, r.motor_d_dir, r.motor_d_speed};
		return f;
	endfunction

	function automatic logic signed [7:0] rand_demand();
		case ($urandom_range(9))
			0: return 8'sd0;
			1: return 8'($urandom_range(255));
			2: return $urandom_range(1) ? fwdm_pkg::PERCENT_FULL : -fwdm_pkg::PERCENT_FULL;
			3: return 8'(int'($urandom_range(10)) - 5);
			default: return 8'(int'($urandom_range(200)) - 100);
		endcase
	endfunction

	task automatic send_cmd(input fwdm_pkg::cmd_t c, input bit known,
			input fwdm_pkg::res_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.payload <= c;
		do @(posedge clk); while (!cmd_if.ready);
		motor_sets_due.push_back(known ? want : mix_demands(c));
	endtask

	task automatic wait_for_results();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (motor_sets_due.size() != 0);
	endtask

	always @(posedge clk) begin
		fwdm_pkg::res_t want;
		motor_fields_t w;
		motor_fields_t g;
		res_if.ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && res_if.valid && res_if.ready) begin
			if (motor_sets_due.size() == 0) begin
				$display("%0t unexpected transaction on res: %p", $time, res_if.payload);
				mismatches++;
			end else begin
				want = motor_sets_due.pop_front();
				w = fields_of(want);
				g = fields_of(res_if.payload);
				for (int i = 0; i < 8; i++) begin
					if (w[i] != g[i]) begin
						$display("%0t %s mismatch: expected %0d, got %0d",
							$time, field_names[i], w[i], g[i]);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) ||
				(res_if.valid && res_if.ready && motor_sets_due.size() != 0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		fwdm_pkg::cmd_t c;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.payload = '0;
		res_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);
		for (int phase = 0; phase < 4; phase++) begin
			wait_for_results();
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 83;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 83;
				end
				default: begin
					send_idle_pct = 25;
					stall_pct = 25;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				c.lateral_demand = rand_demand();
				c.forward_demand = rand_demand();
				c.turn_demand = rand_demand();
				send_cmd(c, 1'b0, '0);
			end
		end
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/fwdm_pkg.sv
rtl/fwdm_stream_if.sv
rtl/fwdm_scale.sv
rtl/fwdm_merge.sv
rtl/fwdm_excess.sv
rtl/fwdm_rebal.sv
rtl/four_wheel_drive_mixer_core.sv
tb/four_wheel_drive_mixer_core_test.sv
